// ===== src/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants of the short id assignment table
// Table size, derived widths, result status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 64;
    localparam int ID_W        = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_EXISTING  = 2'd0,
        STATUS_NEW       = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOOK_RD,
        ST_LOOK_EMIT
    } t_state;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HIT,
        EMIT_NEW,
        EMIT_FULL,
        EMIT_LOOK_HIT,
        EMIT_LOOK_MISS
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  scan;
        logic  look_rd;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic miss;
        logic full;
        logic qid_ok;
    } t_dp_stat;

endpackage

// ===== src/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl: sequencer of the short id assignment table
// Steps a resolve through the table scan and a lookup through its read, and
// tells the datapath which result to emit.
// ----------------------------------------------------------------------------
module sat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_operation,
    input  sat_pkg::t_dp_stat i_stat,
    output sat_pkg::t_cmd     o_cmd,
    output logic              busy
);
    import sat_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = i_operation ? ST_LOOK_RD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.hit || i_stat.miss) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOOK_RD: begin
                n_state = i_stat.qid_ok ? ST_LOOK_EMIT : ST_IDLE;
            end
            ST_LOOK_EMIT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '{load: 1'b0, scan: 1'b0, look_rd: 1'b0, emit: EMIT_NONE};
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = start;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                priority if (i_stat.hit) begin
                    o_cmd.emit = EMIT_HIT;
                end else if (i_stat.miss) begin
                    o_cmd.emit = i_stat.full ? EMIT_FULL : EMIT_NEW;
                end
            end
            ST_LOOK_RD: begin
                o_cmd.look_rd = 1'b1;
                if (!i_stat.qid_ok) begin
                    o_cmd.emit = EMIT_LOOK_MISS;
                end
            end
            ST_LOOK_EMIT: begin
                o_cmd.emit = EMIT_LOOK_HIT;
            end
            default: begin
                o_cmd.emit = EMIT_NONE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// ===== src/sat_datapath.sv =====
// ----------------------------------------------------------------------------
// sat_datapath: address store, entry counter and result register
// One read port streams stored addresses past a single 64-bit comparator;
// the same port serves lookups by id. New addresses append at the fill count.
// ----------------------------------------------------------------------------
module sat_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sat_pkg::t_cmd               i_cmd,
    input  logic [sat_pkg::ADDR_W-1:0]  i_node_address,
    input  logic [sat_pkg::ID_W-1:0]    i_query_id,
    output sat_pkg::t_dp_stat           o_stat,
    output logic                        o_valid,
    output logic [sat_pkg::ID_W-1:0]    o_short_id,
    output logic [sat_pkg::ADDR_W-1:0]  o_found_address,
    output logic [1:0]                  o_status
);
    import sat_pkg::*;

    logic [ADDR_W-1:0]  r_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0]  r_addr;
    logic [ID_W-1:0]    r_qid;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_valid;
    logic               r_valid;
    logic [ID_W-1:0]    r_out_id;
    logic [ADDR_W-1:0]  r_out_addr;
    t_status            r_out_status;

    logic               issue;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
    logic [ID_W-1:0]    qid_m1;
    logic               wr_en;

    assign issue  = i_cmd.scan && (r_idx != r_count);
    assign qid_m1 = r_qid - ID_W'(1);
    assign rd_en  = issue || i_cmd.look_rd;
    assign rd_idx = i_cmd.look_rd ? qid_m1[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign wr_en  = (i_cmd.emit == EMIT_NEW);

    assign o_stat.hit    = r_cmp_valid && (r_rd_data == r_addr);
    assign o_stat.miss   = (r_idx == r_count) && !r_cmp_valid;
    assign o_stat.full   = (r_count == COUNT_W'(TABLE_DEPTH));
    assign o_stat.qid_ok = (r_qid != '0) && (r_qid <= ID_W'(r_count));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_addr;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_node_address;
            r_qid  <= i_query_id;
        end
        r_cmp_idx <= r_idx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx       <= '0;
                r_cmp_valid <= 1'b0;
            end else if (i_cmd.scan) begin
                // advance the scan; compare data lands in the cycle after issue
                r_cmp_valid <= issue;
                if (issue) begin
                    r_idx <= r_idx + COUNT_W'(1);
                end
            end
            if (wr_en) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            EMIT_HIT: begin
                r_out_id     <= ID_W'(r_cmp_idx) + ID_W'(1);
                r_out_addr   <= r_addr;
                r_out_status <= STATUS_EXISTING;
            end
            EMIT_NEW: begin
                r_out_id     <= ID_W'(r_count) + ID_W'(1);
                r_out_addr   <= r_addr;
                r_out_status <= STATUS_NEW;
            end
            EMIT_FULL: begin
                r_out_id     <= '0;
                r_out_addr   <= '0;
                r_out_status <= STATUS_FULL;
            end
            EMIT_LOOK_HIT: begin
                r_out_id     <= r_qid;
                r_out_addr   <= r_rd_data;
                r_out_status <= STATUS_EXISTING;
            end
            EMIT_LOOK_MISS: begin
                r_out_id     <= '0;
                r_out_addr   <= '0;
                r_out_status <= STATUS_NOT_FOUND;
            end
            default: begin
                // hold the last result
                r_out_id     <= r_out_id;
                r_out_addr   <= r_out_addr;
                r_out_status <= r_out_status;
            end
        endcase
    end

    assign o_valid         = r_valid;
    assign o_short_id      = r_out_id;
    assign o_found_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

// ===== src/short_id_assignment_table.sv =====
// ----------------------------------------------------------------------------
// short_id_assignment_table: maps 64-bit node addresses to 16-bit short ids
// A resolve returns the id of a known address or assigns the next one; a
// lookup returns the address stored under an id. Results leave on a strobe.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A resolve holds busy
// while the address store is scanned from slot 0: on a hit until the matching
// slot is compared, and when the address is new or the table is full until
// every filled slot is compared; on an empty table no slot is read. The
// scan runs one stored entry per cycle, set by the single read port of the
// address store feeding one 64-bit comparator. A lookup by id holds busy
// through one store read, then the emit state when the id is assigned. The
// result shows on the output ports for one cycle with o_valid, the cycle after
// busy falls; it is not held, so the receiver must take it then. A new request
// may start in that same cycle. The store needs no clearing after reset; only
// data from filled slots is ever used.
module short_id_assignment_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_operation,
    input  logic [sat_pkg::ADDR_W-1:0]  i_node_address,
    input  logic [sat_pkg::ID_W-1:0]    i_query_id,
    output logic                        o_valid,
    output logic [sat_pkg::ID_W-1:0]    o_short_id,
    output logic [sat_pkg::ADDR_W-1:0]  o_found_address,
    output logic [1:0]                  o_status
);
    import sat_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    sat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy)
    );

    sat_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_node_address  (i_node_address),
        .i_query_id      (i_query_id),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_short_id      (o_short_id),
        .o_found_address (o_found_address),
        .o_status        (o_status)
    );

endmodule

// ===== src/sat_checker.sv =====
// ----------------------------------------------------------------------------
// sat_checker: port-level checks of the short id assignment table
// Relates requests, busy and result strobes over time and checks that each
// status carries consistent id and address fields.
// ----------------------------------------------------------------------------
module sat_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [sat_pkg::ID_W-1:0]    o_short_id,
    input logic [sat_pkg::ADDR_W-1:0]  o_found_address,
    input logic [1:0]                  o_status
);
    import sat_pkg::*;

    // a result only follows a cycle of work
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but block not busy");

    a_no_double_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two results in consecutive cycles");

    a_new_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_NEW)) |-> (o_short_id != '0))
        else $error("newly assigned id is zero");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == STATUS_FULL) || (o_status == STATUS_NOT_FOUND)))
        |-> ((o_short_id == '0) && (o_found_address == '0)))
        else $error("full or not-found result carries data");

endmodule

bind short_id_assignment_table sat_checker u_sat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_short_id      (o_short_id),
    .o_found_address (o_found_address),
    .o_status        (o_status)
);
